FILE: hw/rtl/assert_macros.svh
// Assertion helpers; they expect clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/lmsd_pkg.sv
package lmsd_pkg;

	localparam int MATRIX_SIDE = 16;
	localparam int SCAN_ROWS   = 16;
	localparam int ROW_W       = $clog2(MATRIX_SIDE);
	localparam int WORD_W      = 2 * MATRIX_SIDE;
	localparam int BIT_W       = $clog2(WORD_W);
	localparam int HALF_W      = 10;

	localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(16);
	localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCAN_ROWS - 1);
	localparam logic [BIT_W-1:0]  LAST_BIT   = BIT_W'(WORD_W - 1);

	typedef enum logic [2:0] {
		ACT_WRITE = 3'd0,
		ACT_READ  = 3'd1,
		ACT_CLEAR = 3'd2,
		ACT_START = 3'd3,
		ACT_TICK  = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOW,
		ST_HIGH,
		ST_LATCH,
		ST_LAST
	} state_t;

	typedef struct packed {
		logic capture;
		logic wr;
		logic clr;
		logic rd;
		logic load_row;
		logic row_zero;
		logic row_inc;
		logic phase_inc;
		logic phase_clr;
		logic clk_rise;
		logic next_bit;
		logic done;
		logic latch_nxt;
		logic busy_nxt;
	} cmd_t;

	typedef struct packed {
		logic phase_end;
		logic bit_last;
		logic row_last;
	} sts_t;

endpackage

FILE: hw/rtl/lmsd_if.sv
interface lmsd_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [3:0] row_x;
	logic [3:0] col_y;
	logic       pixel_on;

	modport source (output valid, action, row_x, col_y, pixel_on, input ready);
	modport sink (input valid, action, row_x, col_y, pixel_on, output ready);
endinterface

interface lmsd_out_if;
	logic valid;
	logic ready;
	logic shift_clock;
	logic shift_data;
	logic latch_pulse;
	logic enable_n;
	logic busy_res;
	logic read_value;
	logic scan_done;

	modport source (output valid, shift_clock, shift_data, latch_pulse, enable_n,
		busy_res, read_value, scan_done, input ready);
	modport sink (input valid, shift_clock, shift_data, latch_pulse, enable_n,
		busy_res, read_value, scan_done, output ready);
endinterface

FILE: hw/rtl/lmsd_ctrl.sv
module lmsd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [2:0]    action,
	input  lmsd_pkg::sts_t sts,
	output lmsd_pkg::cmd_t cmd
);
	import lmsd_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		if (accept) begin
			cmd.capture = 1'b1;
			unique case (action_t'(action))
				ACT_WRITE: cmd.wr = 1'b1;
				ACT_READ:  cmd.rd = 1'b1;
				ACT_CLEAR: cmd.clr = 1'b1;
				ACT_START: begin
					// a start while busy is dropped
					if (state_q == ST_IDLE || state_q == ST_LAST) begin
						state_d      = ST_LOW;
						cmd.row_zero = 1'b1;
						cmd.load_row = 1'b1;
					end
				end
				ACT_TICK: begin
					unique case (state_q)
						ST_IDLE: ;
						ST_LAST: state_d = ST_IDLE;
						ST_LATCH: begin
							state_d      = ST_LOW;
							cmd.load_row = 1'b1;
						end
						ST_LOW: begin
							if (!sts.phase_end) begin
								cmd.phase_inc = 1'b1;
							end else begin
								cmd.phase_clr = 1'b1;
								cmd.clk_rise  = 1'b1;
								state_d       = ST_HIGH;
							end
						end
						ST_HIGH: begin
							if (!sts.phase_end) begin
								cmd.phase_inc = 1'b1;
							end else begin
								cmd.phase_clr = 1'b1;
								if (!sts.bit_last) begin
									cmd.next_bit = 1'b1;
									state_d      = ST_LOW;
								end else if (sts.row_last) begin
									cmd.done = 1'b1;
									state_d  = ST_LAST;
								end else begin
									cmd.row_inc = 1'b1;
									state_d     = ST_LATCH;
								end
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
				default: ;
			endcase
		end
		cmd.latch_nxt = (state_d == ST_LATCH) || (state_d == ST_LAST);
		cmd.busy_nxt  = (state_d == ST_LOW) || (state_d == ST_HIGH) || (state_d == ST_LATCH);
	end

endmodule

FILE: hw/rtl/lmsd_datapath.sv
module lmsd_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lmsd_pkg::cmd_t              cmd,
	output lmsd_pkg::sts_t              sts,
	input  logic                        cfg_we,
	input  logic [lmsd_pkg::HALF_W-1:0] cfg_wdata,
	input  logic [3:0]                  row_x,
	input  logic [3:0]                  col_y,
	input  logic                        pixel_on,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic                        shift_clock,
	output logic                        shift_data,
	output logic                        latch_pulse,
	output logic                        busy_res,
	output logic                        read_value,
	output logic                        scan_done
);
	import lmsd_pkg::*;

	logic [MATRIX_SIDE-1:0] frame_q [MATRIX_SIDE];
	logic [HALF_W-1:0]      half_q;
	logic [HALF_W-1:0]      half_eff;
	logic [HALF_W-1:0]      phase_q;
	logic [BIT_W-1:0]       bit_q;
	logic [ROW_W-1:0]       row_q;
	logic [WORD_W-1:0]      word_q;
	logic                   clk_pin_q, dat_pin_q;
	logic                   clk_pin_d, dat_pin_d;
	logic [ROW_W-1:0]       rd_addr;
	logic [MATRIX_SIDE-1:0] rd_data;
	logic [WORD_W-1:0]      new_word;
	logic                   out_valid_q;

	assign half_eff = (half_q == '0) ? HALF_W'(1) : half_q;

	// a phase ends once the count reaches the period, even after a lowered period
	assign sts.phase_end = ({1'b0, phase_q} + (HALF_W+1)'(1)) >= {1'b0, half_eff};
	assign sts.bit_last  = (bit_q == LAST_BIT);
	assign sts.row_last  = (row_q == LAST_ROW);

	// one read port shared by pixel reads and row loads
	assign rd_addr  = cmd.rd ? row_x : (cmd.row_zero ? '0 : row_q);
	assign rd_data  = frame_q[rd_addr];
	assign new_word = {~(MATRIX_SIDE'(1) << rd_addr), ~rd_data};

	always_comb begin
		clk_pin_d = clk_pin_q;
		dat_pin_d = dat_pin_q;
		if (cmd.load_row) begin
			clk_pin_d = 1'b0;
			dat_pin_d = new_word[WORD_W-1];
		end else if (cmd.clk_rise) begin
			clk_pin_d = 1'b1;
		end else if (cmd.next_bit) begin
			clk_pin_d = 1'b0;
			dat_pin_d = word_q[WORD_W-2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MATRIX_SIDE; i++) begin
				frame_q[i] <= '0;
			end
			half_q      <= HALF_RESET;
			phase_q     <= '0;
			bit_q       <= '0;
			row_q       <= '0;
			word_q      <= '0;
			clk_pin_q   <= 1'b0;
			dat_pin_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				half_q <= cfg_wdata;
			end
			if (cmd.clr) begin
				for (int i = 0; i < MATRIX_SIDE; i++) begin
					frame_q[i] <= '0;
				end
			end else if (cmd.wr) begin
				frame_q[row_x][col_y] <= pixel_on;
			end
			if (cmd.row_zero) begin
				row_q <= '0;
			end else if (cmd.row_inc) begin
				row_q <= row_q + ROW_W'(1);
			end
			if (cmd.load_row || cmd.phase_clr) begin
				phase_q <= '0;
			end else if (cmd.phase_inc) begin
				phase_q <= phase_q + HALF_W'(1);
			end
			if (cmd.load_row) begin
				bit_q  <= '0;
				word_q <= new_word;
			end else if (cmd.next_bit) begin
				bit_q  <= bit_q + BIT_W'(1);
				word_q <= word_q << 1;
			end
			clk_pin_q <= clk_pin_d;
			dat_pin_q <= dat_pin_d;
			// hold the word until taken
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			shift_clock <= clk_pin_d;
			shift_data  <= dat_pin_d;
			latch_pulse <= cmd.latch_nxt;
			busy_res    <= cmd.busy_nxt;
			read_value  <= cmd.rd & rd_data[col_y];
			scan_done   <= cmd.done;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/led_matrix_scan_driver.sv
// Each accepted command word's result word is registered for the next cycle.
// Throughput: one command word per cycle while the output is not stalled;
// the output register takes a new word in the cycle its result is taken.
// Scan timing is counted in tick words: 2 * half period ticks per bit, 32 bits
// and one latch tick per row. Reset clears the frame store, counters and pins
// and sets the half period to 16.
module led_matrix_scan_driver (
	input  logic                        clk,
	input  logic                        arst_n,
	lmsd_in_if.sink                     pixel_cmd,
	lmsd_out_if.source                  pin_state,
	input  logic                        cfg_we,
	input  logic [lmsd_pkg::HALF_W-1:0] cfg_wdata
);
	import lmsd_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic accept;

	assign pixel_cmd.ready = !pin_state.valid || pin_state.ready;
	assign accept          = pixel_cmd.valid && pixel_cmd.ready;
	assign pin_state.enable_n = 1'b0;

	lmsd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.action (pixel_cmd.action),
		.sts    (sts),
		.cmd    (cmd)
	);

	lmsd_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.row_x       (pixel_cmd.row_x),
		.col_y       (pixel_cmd.col_y),
		.pixel_on    (pixel_cmd.pixel_on),
		.out_ready   (pin_state.ready),
		.out_valid   (pin_state.valid),
		.shift_clock (pin_state.shift_clock),
		.shift_data  (pin_state.shift_data),
		.latch_pulse (pin_state.latch_pulse),
		.busy_res    (pin_state.busy_res),
		.read_value  (pin_state.read_value),
		.scan_done   (pin_state.scan_done)
	);

endmodule

FILE: hw/rtl/lmsd_checker.sv
`include "assert_macros.svh"

module lmsd_sva (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic enable_n,
	input logic latch_pulse,
	input logic busy_res,
	input logic scan_done
);

	// an empty output stage must never stall the command side
	`ASSERT_ALWAYS(a_ready_when_empty, !out_valid -> in_ready)

	`ASSERT_ALWAYS(a_enable_low, !out_valid || !enable_n)

	// the final latch ends the scan
	`ASSERT_ALWAYS(a_done_latches, !(out_valid && scan_done) || (latch_pulse && !busy_res))

	`ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready,
		out_valid && $stable(scan_done) && $stable(busy_res) && $stable(latch_pulse))

endmodule

bind led_matrix_scan_driver lmsd_sva u_lmsd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (pixel_cmd.ready),
	.out_valid   (pin_state.valid),
	.out_ready   (pin_state.ready),
	.enable_n    (pin_state.enable_n),
	.latch_pulse (pin_state.latch_pulse),
	.busy_res    (pin_state.busy_res),
	.scan_done   (pin_state.scan_done)
);
